>>> hw/rtl/iftg_pkg.sv
// ----------------------------------------------------------------------------
// iftg_pkg
// shared types, constants and the cordic arctangent table
// ----------------------------------------------------------------------------
package iftg_pkg;

  localparam int MAX_TAPS_DEF      = 1024;
  localparam int CORDIC_STAGES_DEF = 18;

  localparam int IDX_W   = 10;
  localparam int ORD_W   = 11;
  localparam int CUT_W   = 16;
  localparam int COEF_W  = 18;
  localparam int KIND_W  = 3;

  // cordic datapath widths (q2.30 with margin, phase in turns)
  localparam int XW = 34;
  localparam int ZW = 33;

  // divider: numerator bits, divisor bits
  localparam int DIV_NW = 20;
  localparam int DIV_VW = 12;
  localparam int AN_W   = 19;
  localparam int SV_W   = 20;
  localparam int VAL_W  = 21;

  localparam logic [CUT_W-1:0] CUT_MAX    = 16'd32768;
  localparam int               ONE_Q16    = 65536;
  localparam logic signed [31:0] TWO_OVER_PI_Q30  = 32'sd683565276;
  localparam logic signed [31:0] FOUR_OVER_PI_Q30 = 32'sd1367130551;
  localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [AN_W-1:0] HILB_NUM  = AN_W'(683565276 >> 13);
  localparam int COEF_MAX = 131071;
  localparam int COEF_MIN = -131072;

  typedef enum logic [KIND_W-1:0] {
    KIND_LP   = 3'd0,
    KIND_HP   = 3'd1,
    KIND_BP   = 3'd2,
    KIND_BS   = 3'd3,
    KIND_HILB = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_KIND   = 2'd0,
    REG_COUNT  = 2'd1,
    REG_CUT_LO = 2'd2,
    REG_CUT_HI = 2'd3
  } reg_idx_t;

  // per-item control that rides along the pipeline
  typedef struct packed {
    logic                   wr;
    logic                   use_div;
    logic                   neg;
    logic                   hilb;
    logic                   band;
    logic signed [SV_W-1:0] sv;
    logic [ORD_W-1:0]       dv;
  } ctl_t;

  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;  1:  r = 32'h12E4051E;  2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;  4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;  8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;  10: r = 32'h000A2F98;  11: r = 32'h000517CC;
      12: r = 32'h00028BE6;  13: r = 32'h000145F3;  14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;  16: r = 32'h000028BE;  17: r = 32'h0000145F;
      18: r = 32'h00000A30;  19: r = 32'h00000518;  20: r = 32'h0000028C;
      21: r = 32'h00000146;  22: r = 32'h000000A3;  23: r = 32'h00000051;
      24: r = 32'h00000029;  25: r = 32'h00000014;  26: r = 32'h0000000A;
      27: r = 32'h00000005;  28: r = 32'h00000003;  29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/iftg_cordic.sv
// ----------------------------------------------------------------------------
// iftg_cordic
// dual-lane pipelined rotation cordic, one iteration per register stage
// ----------------------------------------------------------------------------
module iftg_cordic import iftg_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter int TAG_W  = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [TAG_W-1:0]     in_tag,
  input  logic [31:0]          phase_a,
  input  logic [31:0]          phase_b,
  output logic                 out_vld,
  output logic [TAG_W-1:0]     out_tag,
  output logic signed [XW-1:0] sin_a,
  output logic signed [XW-1:0] cos_b
);

  logic                 vld_r  [0:STAGES];
  logic [TAG_W-1:0]     tag_r  [0:STAGES];
  logic                 flip_r [0:STAGES][2];
  logic signed [XW-1:0] x_r    [0:STAGES][2];
  logic signed [XW-1:0] y_r    [0:STAGES][2];
  logic signed [ZW-1:0] z_r    [0:STAGES][2];

  logic [31:0] ph [2];
  logic [31:0] rot [2];
  logic        flip_w [2];

  assign ph[0] = phase_a;
  assign ph[1] = phase_b;

  // fold the phase into the right half plane
  for (genvar l = 0; l < 2; l++) begin : g_pre
    assign rot[l]    = ph[l] + 32'h40000000;
    assign flip_w[l] = rot[l][31];
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[0][l] <= flip_w[l];
        x_r[0][l]    <= CORDIC_GAIN_Q30;
        y_r[0][l]    <= '0;
        z_r[0][l]    <= ZW'($signed({flip_w[l] ^ ph[l][31], ph[l][30:0]}));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= in_tag;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ANG = ZW'($signed({1'b0, atan_turn(i)}));
    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [XW-1:0] xs, ys;
      assign xs = x_r[i][l] >>> i;
      assign ys = y_r[i][l] >>> i;
      always_ff @(posedge clk) begin
        if (en) begin
          flip_r[i+1][l] <= flip_r[i][l];
          if (!z_r[i][l][ZW-1]) begin
            x_r[i+1][l] <= x_r[i][l] - ys;
            y_r[i+1][l] <= y_r[i][l] + xs;
            z_r[i+1][l] <= z_r[i][l] - ANG;
          end else begin
            x_r[i+1][l] <= x_r[i][l] + ys;
            y_r[i+1][l] <= y_r[i][l] - xs;
            z_r[i+1][l] <= z_r[i][l] + ANG;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[i+1] <= tag_r[i];
      end
    end
  end

  assign out_vld = vld_r[STAGES];
  assign out_tag = tag_r[STAGES];
  assign sin_a   = flip_r[STAGES][0] ? -y_r[STAGES][0] : y_r[STAGES][0];
  assign cos_b   = flip_r[STAGES][1] ? -x_r[STAGES][1] : x_r[STAGES][1];

endmodule

>>> hw/rtl/iftg_div.sv
// ----------------------------------------------------------------------------
// iftg_div
// pipelined restoring divider, one quotient bit per register stage
// ----------------------------------------------------------------------------
module iftg_div import iftg_pkg::*; #(
  parameter int TAG_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [TAG_W-1:0]    in_tag,
  input  logic [DIV_NW-1:0]   num,
  input  logic [DIV_VW-1:0]   den,
  output logic                out_vld,
  output logic [TAG_W-1:0]    out_tag,
  output logic [DIV_NW-1:0]   quo
);

  logic                vld_r [0:DIV_NW];
  logic [TAG_W-1:0]    tag_r [0:DIV_NW];
  logic [DIV_NW-1:0]   num_r [0:DIV_NW];
  logic [DIV_NW-1:0]   quo_r [0:DIV_NW];
  logic [DIV_VW-1:0]   rem_r [0:DIV_NW];
  logic [DIV_VW-1:0]   den_r [0:DIV_NW];

  assign vld_r[0] = in_vld;
  assign tag_r[0] = in_tag;
  assign num_r[0] = num;
  assign quo_r[0] = '0;
  assign rem_r[0] = '0;
  assign den_r[0] = den;

  for (genvar k = 0; k < DIV_NW; k++) begin : g_step
    logic [DIV_VW:0] trial;
    logic            ge;
    assign trial = {rem_r[k], num_r[k][DIV_NW-1]};
    assign ge    = trial >= {1'b0, den_r[k]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[k+1] <= tag_r[k];
        num_r[k+1] <= {num_r[k][DIV_NW-2:0], 1'b0};
        quo_r[k+1] <= {quo_r[k][DIV_NW-2:0], ge};
        rem_r[k+1] <= ge ? DIV_VW'(trial - {1'b0, den_r[k]}) : trial[DIV_VW-1:0];
        den_r[k+1] <= den_r[k];
      end
    end
  end

  assign out_vld = vld_r[DIV_NW];
  assign out_tag = tag_r[DIV_NW];
  assign quo     = quo_r[DIV_NW];

endmodule

>>> hw/rtl/ideal_fir_tap_generator_core.sv
// ----------------------------------------------------------------------------
// ideal_fir_tap_generator_core
// ideal (rectangular window) fir tap generator, one tap per item
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | tvalid / tready    | tdata[9:0] tap_index
//  out_    | out | tvalid / tready    | tdata[17:0] coefficient, tuser tap_written
//  cfg_    | in  | apb, pready tied 1 | kind, tap_count, cutoff_low, cutoff_high
//
//  one item per cycle sustained while the output is not stalled; the pipeline is
//  2 setup stages, 1 + CORDIC_STAGES cordic, 3 multiply/scale, 20 divider and
//  1 output register
//  a stalled output freezes the whole pipeline; in_tready follows the stall
//  synchronous active-low reset clears the valid bits and restores registers
//  configuration is read live and must only change while the pipe is empty
// ----------------------------------------------------------------------------
module ideal_fir_tap_generator_core import iftg_pkg::*; #(
  parameter int MAX_TAPS      = MAX_TAPS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // tap_index [9:0]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,
  // coefficient [17:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,
  // tap_written [0]
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int TAG_W = $bits(ctl_t);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [KIND_W-1:0] kind_r;
  logic [ORD_W-1:0]  count_r;
  logic [CUT_W-1:0]  cut_lo_r;
  logic [CUT_W-1:0]  cut_hi_r;
  reg_idx_t          widx;

  assign cfg_pready = 1'b1;
  assign widx       = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_LP;
      count_r  <= ORD_W'(64);
      cut_lo_r <= 16'd16384;
      cut_hi_r <= 16'd24576;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (widx)
        REG_KIND:   kind_r   <= cfg_pwdata[KIND_W-1:0];
        REG_COUNT:  count_r  <= cfg_pwdata[ORD_W-1:0];
        REG_CUT_LO: cut_lo_r <= cfg_pwdata[CUT_W-1:0];
        REG_CUT_HI: cut_hi_r <= cfg_pwdata[CUT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_KIND:   cfg_prdata = 32'(kind_r);
      REG_COUNT:  cfg_prdata = 32'(count_r);
      REG_CUT_LO: cfg_prdata = 32'(cut_lo_r);
      REG_CUT_HI: cfg_prdata = 32'(cut_hi_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // clamped order and cutoffs, band width and band sum
  logic [ORD_W-1:0]        n_w;
  logic [CUT_W-1:0]        lo_w, hi_w;
  logic signed [CUT_W:0]   d_w;
  logic [CUT_W:0]          u_w;

  assign n_w  = (32'(count_r) > 32'(MAX_TAPS)) ? ORD_W'(MAX_TAPS) : count_r;
  assign lo_w = (cut_lo_r > CUT_MAX) ? CUT_MAX : cut_lo_r;
  assign hi_w = (cut_hi_r > CUT_MAX) ? CUT_MAX : cut_hi_r;
  assign d_w  = $signed({1'b0, hi_w}) - $signed({1'b0, lo_w});
  assign u_w  = {1'b0, hi_w} + {1'b0, lo_w};

  // global advance: the whole pipe moves when the output register can take
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // --------------------------------------------------------------------------
  // stage a: tap classification, distance from centre and special taps
  // --------------------------------------------------------------------------
  logic [IDX_W-1:0] t_w;
  logic [ORD_W-1:0] len_w, two_t1, m_w;
  logic             sym_a, sym_b, ok_w, in_len, pre_c;
  ctl_t             ctl_w;

  assign t_w    = in_tdata[IDX_W-1:0];
  assign two_t1 = {t_w, 1'b1};
  assign sym_a  = (kind_r == KIND_LP) || (kind_r == KIND_BP);
  assign sym_b  = (kind_r == KIND_HP) || (kind_r == KIND_BS) || (kind_r == KIND_HILB);
  // odd-length kinds drop one tap of an even order
  assign len_w  = (sym_b && !n_w[0]) ? n_w - ORD_W'(1) : n_w;
  assign m_w    = (two_t1 >= len_w) ? two_t1 - len_w : len_w - two_t1;
  assign pre_c  = two_t1 < len_w;
  assign in_len = {1'b0, t_w} < len_w;
  assign ok_w   = ({1'b0, t_w} < n_w) &&
                  ((sym_a && n_w >= ORD_W'(2)) || (sym_b && n_w >= ORD_W'(3)));

  always_comb begin
    ctl_w         = '0;
    ctl_w.wr      = ok_w;
    ctl_w.hilb    = kind_r == KIND_HILB;
    ctl_w.band    = (kind_r == KIND_BP) || (kind_r == KIND_BS);
    ctl_w.dv      = ctl_w.hilb ? (m_w >> 1) : m_w;
    if (ok_w && in_len) begin
      case (kind_r)
        KIND_LP: begin
          ctl_w.use_div = m_w != '0;
          ctl_w.sv      = SV_W'($signed({2'b0, lo_w, 1'b0}));
        end
        KIND_HP: begin
          ctl_w.use_div = m_w != '0;
          ctl_w.neg     = 1'b1;
          ctl_w.sv      = SV_W'(ONE_Q16) - SV_W'($signed({2'b0, lo_w, 1'b0}));
        end
        KIND_BP: begin
          ctl_w.use_div = m_w != '0;
          ctl_w.sv      = SV_W'(d_w) <<< 1;
        end
        KIND_BS: begin
          ctl_w.use_div = m_w != '0;
          ctl_w.neg     = 1'b1;
          ctl_w.sv      = SV_W'(ONE_Q16) - (SV_W'(d_w) <<< 1);
        end
        KIND_HILB: begin
          // only odd half-distances carry a term
          ctl_w.use_div = m_w[1];
          ctl_w.neg     = pre_c;
        end
        default: ;
      endcase
      if (m_w != '0) begin
        ctl_w.sv = '0;
      end
    end
  end

  logic             a_vld_r;
  ctl_t             a_ctl_r;
  logic [ORD_W-1:0] a_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_ctl_r <= ctl_w;
      a_m_r   <= m_w;
    end
  end

  // --------------------------------------------------------------------------
  // stage b: phases in turns, only the low 32 bits matter
  // --------------------------------------------------------------------------
  logic [26:0]        mlo_w;
  logic signed [28:0] md_w;
  logic [27:0]        mu_w;
  logic               b_vld_r;
  ctl_t               b_ctl_r;
  logic [31:0]        b_pa_r, b_pb_r;

  assign mlo_w = a_m_r * lo_w;
  assign md_w  = $signed({1'b0, a_m_r}) * d_w;
  assign mu_w  = a_m_r * u_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ctl_r <= a_ctl_r;
      b_pa_r  <= a_ctl_r.band ? {md_w[17:0], 14'b0} : {mlo_w[16:0], 15'b0};
      b_pb_r  <= {mu_w[17:0], 14'b0};
    end
  end

  // --------------------------------------------------------------------------
  // cordic: sine of the first phase, cosine of the second
  // --------------------------------------------------------------------------
  logic                 c_vld;
  logic [TAG_W-1:0]     c_tag;
  ctl_t                 c_ctl;
  logic signed [XW-1:0] c_sin, c_cos;

  iftg_cordic #(
    .STAGES (CORDIC_STAGES),
    .TAG_W  (TAG_W)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (b_vld_r),
    .in_tag  (b_ctl_r),
    .phase_a (b_pa_r),
    .phase_b (b_pb_r),
    .out_vld (c_vld),
    .out_tag (c_tag),
    .sin_a   (c_sin),
    .cos_b   (c_cos)
  );

  assign c_ctl = ctl_t'(c_tag);

  // --------------------------------------------------------------------------
  // m1: band product back to q30 (floor), m2: scale by 2/pi or 4/pi
  // --------------------------------------------------------------------------
  logic signed [2*XW-1:0] prod_w;
  logic signed [2*XW-1:0] prod_sh;
  logic                   m1_vld_r, m2_vld_r, m3_vld_r;
  ctl_t                   m1_ctl_r, m2_ctl_r, m3_ctl_r;
  logic signed [XW-1:0]   m1_pr_r;
  logic signed [65:0]     m2_num_r;
  logic signed [31:0]     k_w;
  logic signed [65:0]     num_w;

  assign prod_w  = c_sin * c_cos;
  assign prod_sh = prod_w >>> 30;
  assign k_w     = m1_ctl_r.band ? FOUR_OVER_PI_Q30 : TWO_OVER_PI_Q30;
  assign num_w   = m1_pr_r * k_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r <= 1'b0;
      m2_vld_r <= 1'b0;
      m3_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r <= c_vld;
      m2_vld_r <= m1_vld_r;
      m3_vld_r <= m2_vld_r;
    end
  end

  // --------------------------------------------------------------------------
  // m3: magnitude, rounding fold into the divider operands
  //   round(|num| / (m << 44)) = floor(((|num| >> 43) + m) / 2m)
  // --------------------------------------------------------------------------
  logic [65:0]       mag_w;
  logic [AN_W-1:0]   an_w;
  ctl_t              m3_nxt;
  logic [DIV_NW-1:0] m3_num_r;
  logic [DIV_VW-1:0] m3_den_r;

  assign mag_w = m2_num_r[65] ? 66'(-m2_num_r) : 66'(m2_num_r);
  assign an_w  = m2_ctl_r.hilb ? HILB_NUM : mag_w[61:43];

  always_comb begin
    m3_nxt     = m2_ctl_r;
    m3_nxt.neg = m2_ctl_r.neg ^ (!m2_ctl_r.hilb && m2_num_r[65]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_ctl_r <= c_ctl;
      m1_pr_r  <= c_ctl.band ? prod_sh[XW-1:0] : c_sin;
      m2_ctl_r <= m1_ctl_r;
      m2_num_r <= num_w;
      m3_ctl_r <= m3_nxt;
      m3_num_r <= DIV_NW'(an_w) + DIV_NW'(m2_ctl_r.dv);
      m3_den_r <= {m2_ctl_r.dv, 1'b0};
    end
  end

  // --------------------------------------------------------------------------
  // divider
  // --------------------------------------------------------------------------
  logic              q_vld;
  logic [TAG_W-1:0]  q_tag;
  ctl_t              q_ctl;
  logic [DIV_NW-1:0] q_w;

  iftg_div #(
    .TAG_W (TAG_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (m3_vld_r),
    .in_tag  (m3_ctl_r),
    .num     (m3_num_r),
    .den     (m3_den_r),
    .out_vld (q_vld),
    .out_tag (q_tag),
    .quo     (q_w)
  );

  assign q_ctl = ctl_t'(q_tag);

  // --------------------------------------------------------------------------
  // output: sign, special taps, saturation
  // --------------------------------------------------------------------------
  logic signed [VAL_W-1:0]  qs_w, val_w;
  logic signed [COEF_W-1:0] coef_nxt;
  logic signed [COEF_W-1:0] coef_r;
  logic                     wr_r;
  logic                     vld_r;

  assign qs_w  = $signed({1'b0, q_w});
  assign val_w = q_ctl.use_div ? (q_ctl.neg ? -qs_w : qs_w) : VAL_W'(q_ctl.sv);

  always_comb begin
    if (val_w > VAL_W'(COEF_MAX)) begin
      coef_nxt = COEF_W'(COEF_MAX);
    end else if (val_w < VAL_W'(COEF_MIN)) begin
      coef_nxt = COEF_W'(COEF_MIN);
    end else begin
      coef_nxt = val_w[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coef_r <= coef_nxt;
      wr_r   <= q_ctl.wr;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {{(24-COEF_W){1'b0}}, coef_r};
  assign out_tuser  = wr_r;

endmodule

>>> test/ideal_fir_tap_generator_core_test.sv
// ----------------------------------------------------------------------------
// ideal_fir_tap_generator_core_test
// self-checking bench: directed table, then random configurations and indices,
// every tap compared with a table value or an in-bench model of the ideal fir design rule
// ----------------------------------------------------------------------------
module ideal_fir_tap_generator_core_test;
  import iftg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LAT       = CORDIC_STAGES_DEF + 27;
  localparam int LIMIT     = 600000;
  localparam int N_PHASES  = 29;
  localparam int PHASE_LEN = 50;

  typedef struct {
    logic signed [COEF_W-1:0] coef;
    bit                       wr;
  } tap_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    int                count;
    int                lo;
    int                hi;
    int                idx;
    bit                typed;  // expected value written in the row
    int                coef;
    bit                wr;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;     // tap_index [9:0], zeros above
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;    // coefficient [17:0], zeros above
  logic        out_tuser;    // tap_written [0]
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // shadow copy of the configuration registers
  logic [KIND_W-1:0] sh_kind;
  logic [ORD_W-1:0]  sh_count;
  logic [CUT_W-1:0]  sh_lo;
  logic [CUT_W-1:0]  sh_hi;

  tap_t  pending_taps[$];
  int    n_sent, n_got, n_bad, n_cfg;
  int    cycles;
  bit    burst_mode;   // sender offers items back to back
  bit    hold_req;     // asks the receiver for one long hold-off
  int    hold_left;

  ideal_fir_tap_generator_core u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // tap model
  // ---------------------------------------------------------------------------
  function automatic longint round_div(input longint num, input longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q   = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // phase in turns (low 32 bits), sine and cosine in q30
  function automatic void cordic_rot(input longint phase, output longint sn,
                                     output longint cs);
    longint p, x, y, z, nx;
    bit     flip;
    p    = phase & 64'hFFFF_FFFF;
    flip = ((p + 64'h4000_0000) & 64'h8000_0000) != 0;
    // fold the left half plane onto the right one
    if (flip) p = (p + 64'h8000_0000) & 64'hFFFF_FFFF;
    z = (p < 64'h8000_0000) ? p : p - 64'h1_0000_0000;
    x = CORDIC_GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(atan_turn(i));
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(atan_turn(i));
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic longint sinc_q16(input longint m, input longint f);
    longint s, c;
    cordic_rot((m * f) << 15, s, c);
    return round_div(s * longint'(TWO_OVER_PI_Q30), m << 44);
  endfunction

  function automatic longint band_q16(input longint m, input longint d,
                                      input longint u);
    longint s1, c1, s2, c2, prod;
    cordic_rot((m * d) << 14, s1, c1);
    cordic_rot((m * u) << 14, s2, c2);
    prod = (s1 * c2) >>> 30;
    return round_div(prod * longint'(FOUR_OVER_PI_Q30), m << 44);
  endfunction

  function automatic tap_t ideal_tap(input int idx);
    tap_t   r;
    longint n, lo, hi, d, u, v, m, len, t;
    bit     wr;
    t  = idx;
    n  = (sh_count > MAX_TAPS_DEF) ? MAX_TAPS_DEF : sh_count;
    lo = (sh_lo > CUT_MAX) ? CUT_MAX : sh_lo;
    hi = (sh_hi > CUT_MAX) ? CUT_MAX : sh_hi;
    d  = hi - lo;
    u  = hi + lo;
    v  = 0;
    wr = 0;
    if (sh_kind == KIND_LP || sh_kind == KIND_BP) begin
      if (n >= 2 && t < n) begin
        wr = 1;
        m  = (2 * t + 1 >= n) ? 2 * t + 1 - n : n - 2 * t - 1;
        if (sh_kind == KIND_LP) v = (m == 0) ? 2 * lo : sinc_q16(m, lo);
        else                    v = (m == 0) ? 2 * d : band_q16(m, d, u);
      end
    end else if (sh_kind == KIND_HP || sh_kind == KIND_BS || sh_kind == KIND_HILB) begin
      if (n >= 3 && t < n) begin
        wr  = 1;
        // even orders drop to odd length, last tap stays zero
        len = n[0] ? n : n - 1;
        if (t < len) begin
          m = (2 * t + 1 >= len) ? 2 * t + 1 - len : len - 2 * t - 1;
          if (sh_kind == KIND_HP)
            v = (m == 0) ? ONE_Q16 - 2 * lo : -sinc_q16(m, lo);
          else if (sh_kind == KIND_BS)
            v = (m == 0) ? ONE_Q16 - 2 * d : -band_q16(m, d, u);
          else if (((m / 2) & 1) != 0) begin
            v = round_div(longint'(TWO_OVER_PI_Q30), (m / 2) << 14);
            if (2 * t + 1 < len) v = -v;
          end
        end
      end
    end
    if (v > COEF_MAX) v = COEF_MAX;
    if (v < COEF_MIN) v = COEF_MIN;
    r.coef = v[COEF_W-1:0];
    r.wr   = wr;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // leaves the bus selected so that writes follow back to back
  task automatic apb_write(input reg_idx_t r, input int value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (r)
      REG_KIND:   sh_kind  = value[KIND_W-1:0];
      REG_COUNT:  sh_count = value[ORD_W-1:0];
      REG_CUT_LO: sh_lo    = value[CUT_W-1:0];
      REG_CUT_HI: sh_hi    = value[CUT_W-1:0];
      default: ;
    endcase
  endtask

  // wait until every tap is back and the pipe has run dry
  task automatic drain_pipe;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_taps.size() != 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task automatic load_config(input int kind, input int count, input int lo,
                             input int hi);
    drain_pipe();
    apb_write(REG_KIND, kind);
    apb_write(REG_COUNT, count);
    apb_write(REG_CUT_LO, lo);
    apb_write(REG_CUT_HI, hi);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    n_cfg++;
  endtask

  // offers one index; the expectation is pushed when the handshake happens
  task automatic send_index(input int idx, input bit typed, input tap_t fixed);
    int r, gap;
    r   = $urandom_range(0, 99);
    gap = (burst_mode || r < 55) ? 0 :
          (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= 16'(idx);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_taps.push_back(typed ? fixed : ideal_tap(idx));
    n_sent++;
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, one long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    int r;
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left  <= 0;
    end else if (hold_req) begin
      hold_req   = 0;
      hold_left  <= 400;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      // long quiet stretches now and then with no stalls at all
      if ((cycles / 500) % 3 == 0) out_tready <= 1'b1;
      else if (r < 70)             out_tready <= 1'b1;
      else if (r < 97)             out_tready <= 1'b0;
      else begin
        out_tready <= 1'b0;
        hold_left  <= $urandom_range(10, 40);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    tap_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_got++;
      if (pending_taps.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected tap: coef %0d written %0b",
                   $signed(out_tdata[COEF_W-1:0]), out_tuser);
      end else begin
        want = pending_taps.pop_front();
        if (out_tdata[COEF_W-1:0] !== want.coef || out_tuser !== want.wr) begin
          n_bad++;
          if (n_bad <= 10)
            $display("tap %0d mismatch: expected coef %0d written %0b, got %0d %0b",
                     n_got, want.coef, want.wr, $signed(out_tdata[COEF_W-1:0]),
                     out_tuser);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d taps outstanding", cycles,
               pending_taps.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    row_t rows[$];
    tap_t fixed;
    int   kind, count, lo, hi, lim, r, idx;

    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    hold_req    = 0;
    burst_mode  = 0;
    cycles      = 0;
    n_sent = 0; n_got = 0; n_bad = 0; n_cfg = 0;
    sh_kind = KIND_LP; sh_count = 64; sh_lo = 16384; sh_hi = 24576;

    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: kind, order, cutoff low/high, index, typed?, coef, written
    rows.push_back('{KIND_LP,   64,    16384, 24576, 0,    0, 0,      0});
    rows.push_back('{KIND_LP,   1,     16384, 24576, 0,    1, 0,      0});
    rows.push_back('{KIND_LP,   3,     16384, 24576, 1,    1, 32768,  1});
    rows.push_back('{KIND_LP,   2047,  65535, 0,     1023, 0, 0,      0});
    rows.push_back('{KIND_LP,   3,     65535, 0,     1,    1, 65536,  1});
    rows.push_back('{KIND_LP,   64,    16384, 24576, 64,   1, 0,      0});
    rows.push_back('{KIND_LP,   0,     16384, 24576, 0,    1, 0,      0});
    rows.push_back('{KIND_LP,   9,     0,     0,     4,    1, 0,      1});
    rows.push_back('{KIND_LP,   1024,  32768, 0,     1023, 0, 0,      0});
    rows.push_back('{KIND_HP,   2,     16384, 0,     0,    1, 0,      0});
    rows.push_back('{KIND_HP,   4,     16384, 0,     3,    1, 0,      1});
    rows.push_back('{KIND_HP,   5,     16384, 0,     2,    1, 32768,  1});
    rows.push_back('{KIND_HP,   40,    9000,  0,     7,    0, 0,      0});
    rows.push_back('{KIND_BP,   3,     0,     32768, 1,    1, 65536,  1});
    rows.push_back('{KIND_BP,   10,    8000,  20000, 0,    0, 0,      0});
    rows.push_back('{KIND_BP,   16,    30000, 2000,  3,    0, 0,      0});
    rows.push_back('{KIND_BS,   3,     32768, 0,     1,    1, 131071, 1});
    rows.push_back('{KIND_BS,   33,    1000,  30000, 5,    0, 0,      0});
    rows.push_back('{KIND_BS,   1024,  0,     32768, 511,  1, 0,      1});
    rows.push_back('{KIND_HILB, 7,     0,     0,     0,    0, 0,      0});
    rows.push_back('{KIND_HILB, 7,     0,     0,     1,    1, 0,      1});
    rows.push_back('{KIND_HILB, 8,     0,     0,     7,    1, 0,      1});
    rows.push_back('{3'd5,      64,    16384, 24576, 3,    1, 0,      0});
    rows.push_back('{3'd7,      64,    16384, 24576, 3,    1, 0,      0});

    foreach (rows[i]) begin
      load_config(rows[i].kind, rows[i].count, rows[i].lo, rows[i].hi);
      fixed.coef = rows[i].coef[COEF_W-1:0];
      fixed.wr   = rows[i].wr;
      send_index(rows[i].idx, rows[i].typed, fixed);
    end

    // random phases, one configuration each
    for (int ph = 0; ph < N_PHASES; ph++) begin
      r = $urandom_range(0, 99);
      kind = (r < 92) ? $urandom_range(0, 4) : $urandom_range(5, 7);
      r = $urandom_range(0, 99);
      if (r < 12) begin
        case ($urandom_range(0, 5))
          0: count = 0;
          1: count = 1;
          2: count = 2;
          3: count = 3;
          4: count = 1024;
          default: count = 2047;
        endcase
      end else if (r < 25) count = $urandom_range(4, 2047);
      else                 count = $urandom_range(2, 80);
      lo = ($urandom_range(0, 99) < 15) ? 32768 * $urandom_range(0, 1) :
           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) :
           $urandom_range(0, 32768);
      hi = ($urandom_range(0, 99) < 15) ? 32768 * $urandom_range(0, 1) :
           ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535) :
           $urandom_range(0, 32768);
      load_config(kind, count, lo, hi);

      // one phase streams without gaps into a long output stall
      if (ph == 3) begin
        burst_mode = 1;
        hold_req   = 1;
      end
      lim = (count > MAX_TAPS_DEF) ? MAX_TAPS_DEF : count;
      for (int k = 0; k < PHASE_LEN; k++) begin
        idx = (lim > 0 && $urandom_range(0, 99) < 85) ? $urandom_range(0, lim - 1)
                                                      : $urandom_range(0, 1023);
        send_index(idx, 0, fixed);
      end
      burst_mode = 0;
    end

    drain_pipe();
    $display("%0d taps sent over %0d configurations, %0d checked, %0d wrong",
             n_sent, n_cfg, n_got, n_bad);
    if (n_bad == 0 && pending_taps.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> ideal_fir_tap_generator_core.f
hw/rtl/iftg_pkg.sv
hw/rtl/iftg_cordic.sv
hw/rtl/iftg_div.sv
hw/rtl/ideal_fir_tap_generator_core.sv
test/ideal_fir_tap_generator_core_test.sv
